// File: src/bsc_pkg.sv
package bsc_pkg;

  typedef enum logic [2:0] {
    CFG_PRESSURE_SENS     = 3'd0,
    CFG_PRESSURE_OFFSET   = 3'd1,
    CFG_SENS_TEMP_COEFF   = 3'd2,
    CFG_OFFSET_TEMP_COEFF = 3'd3,
    CFG_REF_TEMPERATURE   = 3'd4,
    CFG_TEMP_COEFF        = 3'd5
  } cfg_reg_t;

  localparam int unsigned CAL_W     = 16;
  localparam int unsigned RAW_W     = 24;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic signed [18:0] T_REF      = 19'sd2000;
  localparam logic        [17:0] ROUND_HALF = 18'd50;
  // ceil(2^26 / 100): exact quotient for every dividend below 2^20.
  localparam logic        [19:0] RECIP_100  = 20'd671089;
  localparam logic        [11:0] WHOLE_MAX  = 12'd328;

  localparam logic signed [19:0] TC_MAX = 20'sd32767;
  localparam logic signed [19:0] TC_MIN = -20'sd32768;

  localparam logic [20:0] PRESS_MAX = 21'h1FFFFF;

endpackage

// File: src/barometric_sensor_compensation_top.sv
// Channel   Ports                                         Handshake
// input     in_raw_pressure, in_raw_temperature           start high, busy low
// result    out_pressure_sixteenths, out_temperature_*    out_strobe, one cycle
// config    cfg_we, cfg_index, cfg_wdata                  cfg_we high
//
// One beat may enter every cycle; busy is always low.
// Each result passes through the eight register stages of the pipeline
// (multiplies, corrections, split pressure product, final sum and
// saturation).
// Reset clears all stage valid bits and the calibration registers.
// The receiver cannot stall, so the pipeline never holds.
module barometric_sensor_compensation_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bsc_pkg::RAW_W-1:0]      in_raw_pressure,
  input  logic [bsc_pkg::RAW_W-1:0]      in_raw_temperature,
  output logic                           out_strobe,
  output logic [20:0]                    out_pressure_sixteenths,
  output logic signed [15:0]             out_temperature_centi,
  output logic signed [9:0]              out_temperature_whole,
  input  logic                           cfg_we,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsc_pkg::CAL_W-1:0]      cfg_wdata
);

  logic [15:0] cal_c1_r, cal_c2_r, cal_c3_r, cal_c4_r, cal_c5_r, cal_c6_r;
  logic [7:0]  valid_r;
  logic [7:0]  valid_nxt;
  logic        accept;

  logic [23:0]        s1_d1_r;
  logic signed [24:0] s1_dtemp_r, s1_dtemp_nxt;

  logic [23:0]        s2_d1_r;
  logic signed [41:0] s2_m6_r, s2_m4_r, s2_m3_r;
  logic signed [41:0] s2_m6_nxt, s2_m4_nxt, s2_m3_nxt;
  logic signed [49:0] s2_msq;
  logic [16:0]        s2_t2_r;

  logic [23:0]        s3_d1_r;
  logic signed [17:0] s3_diff_r, s3_diff_nxt;
  logic signed [18:0] s3_t1_r, s3_t1_nxt;
  logic               s3_cold_r;
  logic signed [34:0] s3_off_base_r, s3_off_base_nxt;
  logic signed [33:0] s3_sens_base_r, s3_sens_base_nxt;
  logic [16:0]        s3_t2_r;

  logic [23:0]        s4_d1_r;
  logic signed [35:0] s4_sq_full;
  logic [34:0]        s4_sq_r, s4_sq_nxt;
  logic signed [18:0] s4_t1_mag;
  logic [17:0]        s4_abs_r, s4_abs_nxt;
  logic               s4_neg_r;
  logic signed [19:0] s4_tc;
  logic signed [15:0] s4_tcorr_r, s4_tcorr_nxt;
  logic               s4_cold_r;
  logic signed [34:0] s4_off_base_r;
  logic signed [33:0] s4_sens_base_r;

  logic [23:0]        s5_d1_r;
  logic [36:0]        s5_o2_x5;
  logic signed [37:0] s5_off_r, s5_off_nxt;
  logic signed [36:0] s5_sens_r, s5_sens_nxt;
  logic [37:0]        s5_qprod_r, s5_qprod_nxt;
  logic               s5_neg_r;
  logic signed [15:0] s5_tcorr_r;

  logic [41:0]        s6_plo_r, s6_plo_nxt;
  logic signed [43:0] s6_phi_r, s6_phi_nxt;
  logic signed [37:0] s6_off_r;
  logic [11:0]        s6_q;
  logic [9:0]         s6_qsat;
  logic signed [9:0]  s6_whole_r, s6_whole_nxt;
  logic signed [15:0] s6_tcorr_r;

  logic [63:0]        s7_sum_r, s7_sum_nxt;
  logic signed [9:0]  s7_whole_r;
  logic signed [15:0] s7_tcorr_r;

  logic [20:0]        press_nxt;
  logic [20:0]        out_press_r;
  logic signed [15:0] out_tcorr_r;
  logic signed [9:0]  out_whole_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_c1_r <= '0;
      cal_c2_r <= '0;
      cal_c3_r <= '0;
      cal_c4_r <= '0;
      cal_c5_r <= '0;
      cal_c6_r <= '0;
    end else if (cfg_we) begin
      unique case (bsc_pkg::cfg_reg_t'(cfg_index))
        bsc_pkg::CFG_PRESSURE_SENS:     cal_c1_r <= cfg_wdata;
        bsc_pkg::CFG_PRESSURE_OFFSET:   cal_c2_r <= cfg_wdata;
        bsc_pkg::CFG_SENS_TEMP_COEFF:   cal_c3_r <= cfg_wdata;
        bsc_pkg::CFG_OFFSET_TEMP_COEFF: cal_c4_r <= cfg_wdata;
        bsc_pkg::CFG_REF_TEMPERATURE:   cal_c5_r <= cfg_wdata;
        bsc_pkg::CFG_TEMP_COEFF:        cal_c6_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign valid_nxt = {valid_r[6:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_comb begin
    s1_dtemp_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, cal_c5_r, 8'h00});

    s2_m6_nxt = s1_dtemp_r * $signed({1'b0, cal_c6_r});
    s2_m4_nxt = s1_dtemp_r * $signed({1'b0, cal_c4_r});
    s2_m3_nxt = s1_dtemp_r * $signed({1'b0, cal_c3_r});
    s2_msq    = s1_dtemp_r * s1_dtemp_r;

    s3_diff_nxt      = $signed(s2_m6_r[40:23]);
    s3_t1_nxt        = $signed({s3_diff_nxt[17], s3_diff_nxt}) + bsc_pkg::T_REF;
    s3_off_base_nxt  = $signed({3'b000, cal_c2_r, 16'h0000}) + $signed(s2_m4_r[41:7]);
    s3_sens_base_nxt = $signed({3'b000, cal_c1_r, 15'h0000}) + $signed(s2_m3_r[41:8]);

    s4_sq_full = s3_diff_r * s3_diff_r;
    s4_sq_nxt  = s3_cold_r ? s4_sq_full[34:0] : '0;
    s4_t1_mag  = s3_t1_r[18] ? -s3_t1_r : s3_t1_r;
    s4_abs_nxt = s4_t1_mag[17:0] + bsc_pkg::ROUND_HALF;
    s4_tc      = $signed({s3_t1_r[18], s3_t1_r}) - $signed({3'b000, s3_t2_r});
    if (s4_tc > bsc_pkg::TC_MAX) begin
      s4_tcorr_nxt = 16'(bsc_pkg::TC_MAX);
    end else if (s4_tc < bsc_pkg::TC_MIN) begin
      s4_tcorr_nxt = 16'(bsc_pkg::TC_MIN);
    end else begin
      s4_tcorr_nxt = s4_tc[15:0];
    end

    s5_o2_x5     = {2'b00, s4_sq_r} + {s4_sq_r, 2'b00};
    s5_off_nxt   = $signed({{3{s4_off_base_r[34]}}, s4_off_base_r})
                 - $signed({2'b00, s5_o2_x5[36:1]});
    s5_sens_nxt  = $signed({{3{s4_sens_base_r[33]}}, s4_sens_base_r})
                 - $signed({2'b00, s5_o2_x5[36:2]});
    s5_qprod_nxt = s4_abs_r * bsc_pkg::RECIP_100;

    s6_plo_nxt   = s5_d1_r * s5_sens_r[17:0];
    s6_phi_nxt   = $signed({1'b0, s5_d1_r}) * $signed(s5_sens_r[36:18]);
    s6_q         = s5_qprod_r[37:26];
    s6_qsat      = (s6_q > bsc_pkg::WHOLE_MAX) ? bsc_pkg::WHOLE_MAX[9:0] : s6_q[9:0];
    s6_whole_nxt = s5_neg_r ? -$signed(s6_qsat) : $signed(s6_qsat);

    s7_sum_nxt = ({{20{s6_phi_r[43]}}, s6_phi_r} << 18) + {22'b0, s6_plo_r}
               - ({{26{s6_off_r[37]}}, s6_off_r} << 21);

    if (s7_sum_r[63]) begin
      press_nxt = '0;
    end else if (|s7_sum_r[62:53]) begin
      press_nxt = bsc_pkg::PRESS_MAX;
    end else begin
      press_nxt = s7_sum_r[52:32];
    end
  end

  always_ff @(posedge clk) begin
    s1_d1_r    <= in_raw_pressure;
    s1_dtemp_r <= s1_dtemp_nxt;

    s2_d1_r <= s1_d1_r;
    s2_m6_r <= s2_m6_nxt;
    s2_m4_r <= s2_m4_nxt;
    s2_m3_r <= s2_m3_nxt;
    s2_t2_r <= s2_msq[47:31];

    s3_d1_r        <= s2_d1_r;
    s3_diff_r      <= s3_diff_nxt;
    s3_t1_r        <= s3_t1_nxt;
    s3_cold_r      <= s3_diff_nxt[17];
    s3_off_base_r  <= s3_off_base_nxt;
    s3_sens_base_r <= s3_sens_base_nxt;
    s3_t2_r        <= s3_diff_nxt[17] ? s2_t2_r : '0;

    s4_d1_r        <= s3_d1_r;
    s4_sq_r        <= s4_sq_nxt;
    s4_abs_r       <= s4_abs_nxt;
    s4_neg_r       <= s3_t1_r[18];
    s4_tcorr_r     <= s4_tcorr_nxt;
    s4_cold_r      <= s3_cold_r;
    s4_off_base_r  <= s3_off_base_r;
    s4_sens_base_r <= s3_sens_base_r;

    s5_d1_r    <= s4_d1_r;
    s5_off_r   <= s5_off_nxt;
    s5_sens_r  <= s5_sens_nxt;
    s5_qprod_r <= s5_qprod_nxt;
    s5_neg_r   <= s4_neg_r;
    s5_tcorr_r <= s4_tcorr_r;

    s6_plo_r   <= s6_plo_nxt;
    s6_phi_r   <= s6_phi_nxt;
    s6_off_r   <= s5_off_r;
    s6_whole_r <= s6_whole_nxt;
    s6_tcorr_r <= s5_tcorr_r;

    s7_sum_r   <= s7_sum_nxt;
    s7_whole_r <= s6_whole_r;
    s7_tcorr_r <= s6_tcorr_r;

    out_press_r <= press_nxt;
    out_tcorr_r <= s7_tcorr_r;
    out_whole_r <= s7_whole_r;
  end

  assign out_strobe              = valid_r[7];
  assign out_pressure_sixteenths = out_press_r;
  assign out_temperature_centi   = out_tcorr_r;
  assign out_temperature_whole   = out_whole_r;

`ifndef SYNTHESIS
  // The corrected temperature never exceeds the first-order one, so a
  // result of at least half a degree must round to a positive whole degree.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_temperature_centi >= 16'sd50)) |-> (out_temperature_whole >= 10'sd1))
    else $error("whole temperature disagrees with corrected temperature");

  // Above the threshold the offset carries no second-order correction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[3] && !s4_cold_r) |=> (s5_off_r == 38'($past(s4_off_base_r))))
    else $error("offset corrected while not cold");

  // Above the threshold the temperature correction is zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r[2] && !s3_cold_r) |-> (s3_t2_r == '0))
    else $error("temperature corrected while not cold");
`endif

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bsc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int NUM_PHASES       = 10;
  localparam int BEATS_PER_PHASE  = 120;
  localparam int DIR_N            = 20;
  localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;

  typedef logic [5:0][CAL_W-1:0] cal_set_t;

  typedef struct packed {
    logic [20:0] press;
    logic [15:0] centi;
    logic [9:0]  whole;
  } baro_result_t;

  typedef enum logic [2:0] {
    PROF_ZERO, PROF_SENS_MAX, PROF_OFF_MAX, PROF_HOT, PROF_COLD, PROF_TYPICAL, PROF_FULL
  } cal_profile_t;

  typedef struct packed {
    cal_profile_t prof;
    logic [RAW_W-1:0] raw_p;
    logic [RAW_W-1:0] raw_t;
    logic typed;
    baro_result_t want;
  } baro_vector_t;

  localparam baro_result_t AT_REFERENCE = '{21'd0, 16'd2000, 10'd20};
  localparam baro_result_t UNUSED       = '0;

  localparam baro_vector_t DIRECTED [DIR_N] = '{
    '{PROF_ZERO,     24'h000000, 24'h000000, 1'b1, AT_REFERENCE},
    '{PROF_ZERO,     24'hFFFFFF, 24'hFFFFFF, 1'b1, AT_REFERENCE},
    '{PROF_ZERO,     24'hAAAAAA, 24'h555555, 1'b1, AT_REFERENCE},
    '{PROF_SENS_MAX, 24'hFFFFFF, 24'h000000, 1'b1, '{PRESS_MAX, 16'd2000, 10'd20}},
    '{PROF_SENS_MAX, 24'h000000, 24'hFFFFFF, 1'b1, AT_REFERENCE},
    '{PROF_SENS_MAX, 24'h123456, 24'h000000, 1'b0, UNUSED},
    '{PROF_OFF_MAX,  24'hFFFFFF, 24'h000000, 1'b1, AT_REFERENCE},
    '{PROF_HOT,      24'h000000, 24'hFFFFFF, 1'b1, '{21'd0, 16'sd32767, 10'sd328}},
    '{PROF_HOT,      24'h000000, 24'h000000, 1'b1, AT_REFERENCE},
    '{PROF_HOT,      24'h000000, 24'd6401,   1'b1, '{21'd0, 16'd2050, 10'd21}},
    '{PROF_COLD,     24'h000000, 24'h000000, 1'b1, '{PRESS_MAX, 16'sh8000, -10'sd328}},
    '{PROF_COLD,     24'hFFFFFF, 24'h000000, 1'b0, UNUSED},
    '{PROF_COLD,     24'h000000, 24'd16501756, 1'b0, UNUSED},
    '{PROF_TYPICAL,  24'd9085466, 24'd8569150, 1'b0, UNUSED},
    '{PROF_TYPICAL,  24'd9085466, 24'd8000000, 1'b0, UNUSED},
    '{PROF_TYPICAL,  24'd9085466, 24'd9500000, 1'b0, UNUSED},
    '{PROF_TYPICAL,  24'hFFFFFF, 24'h000000, 1'b0, UNUSED},
    '{PROF_FULL,     24'hFFFFFF, 24'hFFFFFF, 1'b0, UNUSED},
    '{PROF_FULL,     24'h000000, 24'h000000, 1'b0, UNUSED},
    '{PROF_FULL,     24'h800000, 24'h800000, 1'b0, UNUSED}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [RAW_W-1:0]     in_raw_pressure = '0;
  logic [RAW_W-1:0]     in_raw_temperature = '0;
  logic                 out_strobe;
  logic [20:0]          out_pressure_sixteenths;
  logic signed [15:0]   out_temperature_centi;
  logic signed [9:0]    out_temperature_whole;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CAL_W-1:0]     cfg_wdata = '0;

  cal_set_t     cal_word = '0;
  baro_result_t next_reading = '0;
  baro_result_t oldest_reading;
  baro_result_t pending_readings [$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           burst_left = 0;

  barometric_sensor_compensation_top dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_raw_pressure         (in_raw_pressure),
    .in_raw_temperature      (in_raw_temperature),
    .out_strobe              (out_strobe),
    .out_pressure_sixteenths (out_pressure_sixteenths),
    .out_temperature_centi   (out_temperature_centi),
    .out_temperature_whole   (out_temperature_whole),
    .cfg_we                  (cfg_we),
    .cfg_index               (cfg_index),
    .cfg_wdata               (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic baro_result_t compensate(input logic [RAW_W-1:0] raw_p,
                                              input logic [RAW_W-1:0] raw_t);
    longint p, dt, t1, t2, o2, s2, diff, off, sens, whole, centi, press;
    longint sens_ref, off_ref, sens_tc, off_tc, t_ref, t_coeff;
    baro_result_t r;
    p        = raw_p;
    dt       = raw_t;
    sens_ref = cal_word[CFG_PRESSURE_SENS];
    off_ref  = cal_word[CFG_PRESSURE_OFFSET];
    sens_tc  = cal_word[CFG_SENS_TEMP_COEFF];
    off_tc   = cal_word[CFG_OFFSET_TEMP_COEFF];
    t_ref    = cal_word[CFG_REF_TEMPERATURE];
    t_coeff  = cal_word[CFG_TEMP_COEFF];

    dt = dt - t_ref * 256;
    t1 = 2000 + ((dt * t_coeff) >>> 23);
    if (t1 >= 0) begin
      whole = (t1 + 50) / 100;
    end else begin
      whole = -((50 - t1) / 100);
    end
    off  = off_ref * 65536 + ((off_tc * dt) >>> 7);
    sens = sens_ref * 32768 + ((sens_tc * dt) >>> 8);
    if (t1 < 2000) begin
      diff = t1 - 2000;
      t2   = (dt * dt) >>> 31;
      o2   = (5 * diff * diff) / 2;
      s2   = o2 / 2;
    end else begin
      t2 = 0;
      o2 = 0;
      s2 = 0;
    end
    centi = t1 - t2;
    off   = off - o2;
    sens  = sens - s2;
    press = (p * sens - off * 2097152) >>> 32;

    if (press < 0) press = 0;
    if (press > 2097151) press = 2097151;
    if (centi < -32768) centi = -32768;
    if (centi > 32767) centi = 32767;
    if (whole < -328) whole = -328;
    if (whole > 328) whole = 328;
    r.press = press[20:0];
    r.centi = centi[15:0];
    r.whole = whole[9:0];
    return r;
  endfunction

  function automatic cal_set_t profile_words(input cal_profile_t prof);
    cal_set_t w;
    w = '0;
    case (prof)
      PROF_SENS_MAX: begin
        w[CFG_PRESSURE_SENS] = 16'hFFFF;
      end
      PROF_OFF_MAX: begin
        w[CFG_PRESSURE_OFFSET] = 16'hFFFF;
      end
      PROF_HOT: begin
        w[CFG_TEMP_COEFF] = 16'hFFFF;
      end
      PROF_COLD: begin
        w[CFG_REF_TEMPERATURE] = 16'hFFFF;
        w[CFG_TEMP_COEFF]      = 16'hFFFF;
      end
      PROF_TYPICAL: begin
        w[CFG_PRESSURE_SENS]     = 16'd40127;
        w[CFG_PRESSURE_OFFSET]   = 16'd36924;
        w[CFG_SENS_TEMP_COEFF]   = 16'd23317;
        w[CFG_OFFSET_TEMP_COEFF] = 16'd23282;
        w[CFG_REF_TEMPERATURE]   = 16'd33464;
        w[CFG_TEMP_COEFF]        = 16'd28312;
      end
      PROF_FULL: begin
        w = '1;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

  function automatic cal_set_t phase_words(input int phase);
    cal_set_t w;
    cfg_reg_t reg_id;
    if (phase == 0) begin
      w = profile_words(PROF_FULL);
    end else if (phase == 1) begin
      w = profile_words(PROF_ZERO);
    end else if (phase % 2 == 0) begin
      w = profile_words(PROF_TYPICAL);
      reg_id = reg_id.first();
      repeat (reg_id.num()) begin
        w[reg_id] = w[reg_id] + CAL_W'($urandom_range(0, 4095)) - CAL_W'(2048);
        reg_id = reg_id.next();
      end
    end else begin
      w = {$urandom(), $urandom(), $urandom()};
    end
    return w;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(5, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d readings outstanding", $time,
               pending_readings.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      pending_readings.push_back(next_reading);
    end
    if (rst_n && out_strobe) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected beat, pressure %0d centi %0d whole %0d", $time,
                 out_pressure_sixteenths, out_temperature_centi, out_temperature_whole);
        mismatches++;
      end else begin
        oldest_reading = pending_readings.pop_front();
        check_field("pressure_sixteenths", oldest_reading.press, out_pressure_sixteenths);
        check_field("temperature_centi", $signed(oldest_reading.centi),
                    out_temperature_centi);
        check_field("temperature_whole", $signed(oldest_reading.whole),
                    out_temperature_whole);
      end
    end
  end

  task automatic send_beat(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t,
                           input baro_result_t want, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start              <= 1'b1;
    in_raw_pressure    <= raw_p;
    in_raw_temperature <= raw_t;
    next_reading       <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_readings();
    start <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_cal(input cal_set_t words);
    cfg_reg_t reg_id;
    drain_readings();
    reg_id = reg_id.first();
    repeat (reg_id.num()) begin
      write_cal(reg_id, words[reg_id]);
      reg_id = reg_id.next();
    end
    write_cal(CFG_IDX_SPARE_LO, CAL_W'($urandom()));
    write_cal(CFG_IDX_SPARE_HI, CAL_W'($urandom()));
    cfg_we   <= 1'b0;
    cal_word  = words;
  endtask

  initial begin : stimulus
    cal_profile_t current;
    baro_vector_t row;
    baro_result_t want;
    logic [RAW_W-1:0] raw_p, raw_t;
    logic centred;
    int centre, spread, t_val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    current = PROF_ZERO;
    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.prof != current) begin
        apply_cal(profile_words(row.prof));
        current = row.prof;
      end
      want = row.typed ? row.want : compensate(row.raw_p, row.raw_t);
      send_beat(row.raw_p, row.raw_t, want, next_gap());
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      apply_cal(phase_words(phase));
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        centre = int'(cal_word[CFG_REF_TEMPERATURE]) << 8;
        case ($urandom_range(0, 5))
          0, 1: begin
            raw_p   = RAW_W'($urandom());
            raw_t   = RAW_W'($urandom());
            centred = 1'b0;
          end
          2: begin
            raw_p   = RAW_W'($urandom());
            spread  = 1 << $urandom_range(4, 17);
            t_val   = centre + int'($urandom_range(0, 2 * spread)) - spread;
            centred = 1'b1;
          end
          3: begin
            raw_p   = $urandom_range(0, 1) ? RAW_MAX : '0;
            raw_t   = $urandom_range(0, 1) ? RAW_MAX : RAW_W'($urandom());
            centred = 1'b0;
          end
          default: begin
            raw_p   = RAW_W'(9000000 + int'($urandom_range(0, 4194304)) - 2097152);
            t_val   = centre + int'($urandom_range(0, 4194304)) - 2097152;
            centred = 1'b1;
          end
        endcase
        if (raw_p === 'x) raw_p = '0;
        if (t_val < 0) t_val = 0;
        if (t_val > int'(RAW_MAX)) t_val = int'(RAW_MAX);
        if (centred) begin
          raw_t = RAW_W'(t_val);
        end
        if ($urandom_range(0, 99) == 0) begin
          drain_readings();
        end
        send_beat(raw_p, raw_t, compensate(raw_p, raw_t), next_gap());
        t_val = 0;
      end
    end

    drain_readings();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
